### hdl/psfp_pkg.sv
// Shared constants and types of the particle sensor frame parser.
package psfp_pkg;

    localparam logic [7:0]  HDR_FIRST       = 8'h42;
    localparam logic [7:0]  HDR_SECOND      = 8'h4d;
    localparam logic [15:0] HDR_SUM         = 16'h008f;
    localparam logic [4:0]  HDR_NEXT_POS    = 5'd2;
    localparam logic [4:0]  SUM_BYTES       = 5'd30;
    localparam logic [4:0]  LAST_BYTE       = 5'd31;
    localparam logic [4:0]  FIRST_WORD_BYTE = 5'd4;
    localparam logic [4:0]  LAST_WORD_BYTE  = 5'd27;
    localparam int          WORD_COUNT      = 12;
    localparam logic [3:0]  LAST_WORD       = 4'd11;

    typedef struct packed {
        logic        en;
        logic [3:0]  addr;
        logic [15:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic valid;
        logic ok;
    } frame_done_t;

endpackage

### hdl/particle_sensor_frame_parser_core.sv
// Top level of the particle sensor frame parser: collector, word memory and emitter.
//
// Input channel: one received serial byte per item on rx_byte, qualified by
// in_valid and held off by in_stall. The block hunts for the header 0x42 0x4d,
// then takes 30 more frame bytes whatever their value. A header mismatch drops
// the partial header; a 0x42 in its place starts a new one.
// Output channel: after the last frame byte the twelve measurement words come
// out in order on word_index / word_value, each with checksum_ok (16-bit sum of
// bytes 0-29 against the big-endian word in bytes 30-31), last marking word 11.
// Words are emitted even when the checksum fails.
// The collector takes a byte whenever one is offered and in_stall is low. After
// the last frame byte the emitter enters its read state, which loads the memory
// read register, and then its show state, which presents the word; every word
// passes through both states. in_stall stays high from the cycle after the last
// frame byte until word 11 is taken.
// A receiver stall holds the current word and its flags; the memory read
// register is not reloaded until the word is taken.
// Reset (rst_n low, asynchronous) returns to header hunt and drops any pending
// output; the word memory is not cleared, every word is written before it is read.
module particle_sensor_frame_parser_core
    import psfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  word_index,
    output logic [15:0] word_value,
    output logic        checksum_ok,
    output logic        last
);

    logic        in_accept;
    logic        busy;
    mem_wr_t     wr;
    frame_done_t done;
    logic        rd_en;
    logic [3:0]  rd_addr;

    // Hold off input while a frame drains, so writes never meet pending reads.
    assign in_stall  = busy;
    assign in_accept = in_valid && !in_stall;

    psfp_collector u_collector (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .rx_byte (rx_byte),
        .wr      (wr),
        .done    (done)
    );

    psfp_word_mem u_word_mem (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (word_value)
    );

    psfp_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .done        (done),
        .out_stall   (out_stall),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .busy        (busy),
        .out_valid   (out_valid),
        .word_index  (word_index),
        .checksum_ok (checksum_ok),
        .last        (last)
    );

    // A word on the output always means the input is held off.
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("output word shown while input is open");

    // The last flag marks word 11 only.
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (word_index == LAST_WORD))
        else $error("last flag on a word other than the final one");

    // After a word is taken, the next one first needs a memory read.
    a_read_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid)
        else $error("word shown without a preceding memory read");

    // No memory write while the emitter is draining a frame.
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !wr.en)
        else $error("word memory written during readout");

endmodule

### hdl/psfp_word_mem.sv
// Twelve-entry measurement word memory, one write port and one registered read port.
module psfp_word_mem
    import psfp_pkg::*;
(
    input  logic        clk,
    input  mem_wr_t     wr,
    input  logic        rd_en,
    input  logic [3:0]  rd_addr,
    output logic [15:0] rd_data
);

    logic [15:0] mem [WORD_COUNT];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/psfp_collector.sv
// Header hunt, frame byte counting, checksum sum and word assembly.
module psfp_collector
    import psfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  rx_byte,
    output mem_wr_t     wr,
    output frame_done_t done
);

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_HDR2 = 3'b010,
        PH_BODY = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  hold_reg, hold_next;
    logic [7:0]  chk_hi_reg, chk_hi_next;
    logic [4:0]  offset;

    assign offset = pos_reg - FIRST_WORD_BYTE;

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        hold_next   = hold_reg;
        chk_hi_next = chk_hi_reg;
        wr          = '0;
        done        = '0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HDR2:
                begin
                    if (rx_byte == HDR_SECOND)
                    begin
                        phase_next = PH_BODY;
                        pos_next   = HDR_NEXT_POS;
                        sum_next   = HDR_SUM;
                    end
                    else if (rx_byte != HDR_FIRST)
                    begin
                        phase_next  = PH_HUNT;
                        pos_next    = '0;
                        sum_next    = '0;
                        hold_next   = '0;
                        chk_hi_next = '0;
                    end
                end
                PH_BODY:
                begin
                    if (pos_reg < SUM_BYTES)
                    begin
                        sum_next = sum_reg + {8'd0, rx_byte};
                    end
                    if (pos_reg >= FIRST_WORD_BYTE && pos_reg <= LAST_WORD_BYTE)
                    begin
                        if (!offset[0])
                        begin
                            hold_next = rx_byte;
                        end
                        else
                        begin
                            wr.en   = 1'b1;
                            wr.addr = offset[4:1];
                            wr.data = {hold_reg, rx_byte};
                        end
                    end
                    if (pos_reg == SUM_BYTES)
                    begin
                        chk_hi_next = rx_byte;
                    end
                    if (pos_reg == LAST_BYTE)
                    begin
                        done.valid  = 1'b1;
                        done.ok     = ({chk_hi_reg, rx_byte} == sum_reg);
                        phase_next  = PH_HUNT;
                        pos_next    = '0;
                        sum_next    = '0;
                        hold_next   = '0;
                        chk_hi_next = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 5'd1;
                    end
                end
                default:
                begin
                    phase_next  = (rx_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
                    pos_next    = '0;
                    sum_next    = '0;
                    hold_next   = '0;
                    chk_hi_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            pos_reg    <= '0;
            sum_reg    <= '0;
            hold_reg   <= '0;
            chk_hi_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            hold_reg   <= hold_next;
            chk_hi_reg <= chk_hi_next;
        end
    end

endmodule

### hdl/psfp_emitter.sv
// Reads the twelve words back from memory and presents them on the output channel.
module psfp_emitter
    import psfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  frame_done_t done,
    input  logic        out_stall,
    output logic        rd_en,
    output logic [3:0]  rd_addr,
    output logic        busy,
    output logic        out_valid,
    output logic [3:0]  word_index,
    output logic        checksum_ok,
    output logic        last
);

    typedef enum logic [2:0] {
        EM_IDLE = 3'b001,
        EM_READ = 3'b010,
        EM_SHOW = 3'b100
    } em_state_t;

    em_state_t  state_reg, state_next;
    logic [3:0] idx_reg, idx_next;
    logic       ok_reg, ok_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ok_next    = ok_reg;
        unique case (state_reg)
            EM_IDLE:
            begin
                if (done.valid)
                begin
                    state_next = EM_READ;
                    idx_next   = '0;
                    ok_next    = done.ok;
                end
            end
            EM_READ:
            begin
                state_next = EM_SHOW;
            end
            EM_SHOW:
            begin
                if (!out_stall)
                begin
                    if (idx_reg == LAST_WORD)
                    begin
                        state_next = EM_IDLE;
                    end
                    else
                    begin
                        state_next = EM_READ;
                        idx_next   = idx_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EM_IDLE;
            idx_reg   <= '0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ok_reg    <= ok_next;
        end
    end

    assign rd_en       = (state_reg == EM_READ);
    assign rd_addr     = idx_reg;
    assign busy        = (state_reg != EM_IDLE);
    assign out_valid   = (state_reg == EM_SHOW);
    assign word_index  = idx_reg;
    assign checksum_ok = ok_reg;
    assign last        = (idx_reg == LAST_WORD);

endmodule

### dv/frame_checker.sv
// Checker for the particle sensor frame parser: watches both channels, predicts and compares.
module frame_checker
    import psfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  word_index,
    input  logic [15:0] word_value,
    input  logic        checksum_ok,
    input  logic        last,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {SYNC_HUNT, SYNC_HDR2, SYNC_BODY} sync_t;

    typedef struct packed {
        logic [3:0]  index;
        logic [15:0] value;
        logic        ok;
        logic        last;
    } word_t;

    sync_t       sync;
    logic [4:0]  frame_pos;
    logic [15:0] byte_sum;
    logic [7:0]  word_hi;
    logic [7:0]  chk_hi;
    logic [15:0] frame_words [WORD_COUNT];
    word_t       expected_words [$];

    task automatic restart_hunt();
        sync      = SYNC_HUNT;
        frame_pos = '0;
        byte_sum  = '0;
        word_hi   = '0;
        chk_hi    = '0;
    endtask

    // Advance the frame state by one byte; queue the twelve words on the last one.
    task automatic parse_byte(input logic [7:0] b);
        logic [4:0]  rel;
        logic        sum_match;
        word_t       w;
        case (sync)
            SYNC_HDR2:
            begin
                if (b == HDR_SECOND)
                begin
                    sync      = SYNC_BODY;
                    frame_pos = HDR_NEXT_POS;
                    byte_sum  = HDR_SUM;
                end
                else if (b != HDR_FIRST)
                begin
                    restart_hunt();
                end
            end
            SYNC_BODY:
            begin
                if (frame_pos < SUM_BYTES)
                    byte_sum = byte_sum + 16'(b);
                if (frame_pos >= FIRST_WORD_BYTE && frame_pos <= LAST_WORD_BYTE)
                begin
                    rel = frame_pos - FIRST_WORD_BYTE;
                    if (!rel[0])
                        word_hi = b;
                    else
                        frame_words[rel[4:1]] = {word_hi, b};
                end
                if (frame_pos == SUM_BYTES)
                    chk_hi = b;
                if (frame_pos == LAST_BYTE)
                begin
                    sum_match = ({chk_hi, b} == byte_sum);
                    for (int k = 0; k < WORD_COUNT; k++)
                    begin
                        w.index = 4'(k);
                        w.value = frame_words[k];
                        w.ok    = sum_match;
                        w.last  = (4'(k) == LAST_WORD);
                        expected_words.push_back(w);
                    end
                    restart_hunt();
                end
                else
                begin
                    frame_pos = frame_pos + 5'd1;
                end
            end
            default:
            begin
                restart_hunt();
                if (b == HDR_FIRST)
                    sync = SYNC_HDR2;
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned seen);
        if (want != seen)
        begin
            $error("%s: expected %0d, actual %0d", name, want, seen);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        word_t want;
        if (!rst_n)
        begin
            restart_hunt();
            expected_words.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("word_index: expected none, actual %0d (value %0d)",
                           word_index, word_value);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("word_index", want.index, word_index);
                    check_field("word_value", want.value, word_value);
                    check_field("checksum_ok", want.ok, checksum_ok);
                    check_field("last", want.last, last);
                end
            end
            if (in_valid && !in_stall)
                parse_byte(rx_byte);
        end
        pending = expected_words.size();
    end

endmodule

### dv/testbench.sv
// Top of the frame parser testbench: clock, reset, byte stimulus and verdict.
module testbench
    import psfp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // How the 28 frame bytes after the header are filled before sealing.
    typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM, FILL_HEADERS} fill_t;

    localparam int ITEM_COUNT   = 210;   // lower bound on input bytes in the whole run
    localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 60;    // one full frame drain plus margin

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  word_index;
    logic [15:0] word_value;
    logic        checksum_ok;
    logic        last;

    int          fail_count;
    int          pending;
    int          sent_bytes;
    int          idle_cycles;
    bit          calm;             // suppress all idling on both sides
    logic [7:0]  frame_buf [32];

    particle_sensor_frame_parser_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .word_index  (word_index),
        .word_value  (word_value),
        .checksum_ok (checksum_ok),
        .last        (last)
    );

    frame_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .word_index  (word_index),
        .word_value  (word_value),
        .checksum_ok (checksum_ok),
        .last        (last),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: stall about 15% of cycles, never during a calm stretch.
    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(99) < 15);

    // Watchdog: end the run if neither channel moves an item for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles = 0;
        end
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Offer one byte and hold it until the block takes it. Called at a falling
    // edge, returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        sent_bytes++;
        @(negedge clk);
    endtask

    // Build header plus body; the checksum is left to seal_frame.
    task automatic load_frame(input fill_t kind);
        frame_buf[0] = HDR_FIRST;
        frame_buf[1] = HDR_SECOND;
        for (int i = 2; i < SUM_BYTES; i++)
        begin
            case (kind)
                FILL_ZERO:    frame_buf[i] = 8'h00;
                FILL_ONES:    frame_buf[i] = 8'hff;
                FILL_HEADERS: frame_buf[i] = i[0] ? HDR_SECOND : HDR_FIRST;
                default:      frame_buf[i] = 8'($urandom_range(255));
            endcase
        end
    endtask

    // Write the checksum word; a nonzero flip corrupts the given bits.
    task automatic seal_frame(input logic [15:0] flip);
        logic [15:0] sum;
        sum = '0;
        for (int i = 0; i < SUM_BYTES; i++)
            sum = sum + 16'(frame_buf[i]);
        sum = sum ^ flip;
        frame_buf[30] = sum[15:8];
        frame_buf[31] = sum[7:0];
    endtask

    task automatic send_frame();
        for (int i = 0; i < 32; i++)
            send_byte(frame_buf[i]);
    endtask

    initial
    begin
        logic [7:0] b;
        int         pick;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = 8'h00;
        calm      = 1'b0;
        sent_bytes = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Stray bytes while hunting, including a lone second header byte.
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(HDR_SECOND);
        // Broken header: drop back to hunting.
        send_byte(HDR_FIRST);
        send_byte(8'h11);
        // Repeated first header byte restarts the header.
        send_byte(HDR_FIRST);
        load_frame(FILL_ZERO);
        seal_frame(16'h0000);
        send_frame();
        // Two frames back to back with no idling on either side.
        calm = 1'b1;
        // All-ones body: maximum words, length field and reserved bytes.
        load_frame(FILL_ONES);
        seal_frame(16'h0000);
        send_frame();
        // Header bytes inside the body must not restart the hunt; bad checksum high.
        load_frame(FILL_HEADERS);
        seal_frame(16'h0100);
        send_frame();
        calm = 1'b0;
        // Bad checksum low byte only.
        load_frame(FILL_RANDOM);
        seal_frame(16'h0001);
        send_frame();
        // Checksum word at its maximum.
        load_frame(FILL_RANDOM);
        frame_buf[30] = 8'hff;
        frame_buf[31] = 8'hff;
        send_frame();

        // Random part: mostly well-formed frames, some noise and broken headers.
        while (sent_bytes < ITEM_COUNT)
        begin
            pick = $urandom_range(99);
            if (pick < 70 && sent_bytes + 32 <= ITEM_COUNT)
            begin
                load_frame(FILL_RANDOM);
                seal_frame(($urandom_range(99) < 75) ? 16'h0000
                                                      : 16'($urandom_range(16'hffff, 1)));
                send_frame();
            end
            else if (pick < 85)
            begin
                // Noise: never a second header byte, so no frame starts by accident.
                repeat ($urandom_range(6, 1))
                begin
                    b = $urandom_range(1) ? HDR_FIRST : 8'($urandom_range(255));
                    if (b == HDR_SECOND)
                        b = 8'h4c;
                    send_byte(b);
                end
            end
            else
            begin
                send_byte(HDR_FIRST);
                b = 8'($urandom_range(255));
                if (b == HDR_SECOND)
                    b = 8'h00;
                send_byte(b);
            end
        end

        // Drop valid, let the last frame drain, then give the verdict.
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
hdl/psfp_pkg.sv
hdl/psfp_word_mem.sv
hdl/psfp_collector.sv
hdl/psfp_emitter.sv
hdl/particle_sensor_frame_parser_core.sv
dv/frame_checker.sv
dv/testbench.sv
